@@ rtl/mfn_pkg.sv @@
// Package: constants and codes shared by the maze floodfill navigator.
`default_nettype none
package mfn_pkg;
   localparam int MAZE_SIDE   = 16;
   localparam int STACK_DEPTH = 512;
   localparam int CELL_COUNT  = MAZE_SIDE * MAZE_SIDE;
   localparam int COORD_W     = $clog2(MAZE_SIDE);
   localparam int CELL_W      = 2 * COORD_W;
   localparam int DIST_W      = $clog2(CELL_COUNT + 1);
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int SA_W        = $clog2(STACK_DEPTH);
   localparam int HALF        = MAZE_SIDE / 2;
   localparam logic [DIST_W-1:0] UNREACHABLE = DIST_W'(CELL_COUNT);

   localparam logic [2:0] MOVE_FORWARD = 3'd0;
   localparam logic [2:0] MOVE_CW      = 3'd1;
   localparam logic [2:0] MOVE_CCW     = 3'd2;
   localparam logic [2:0] MOVE_AROUND  = 3'd3;
   localparam logic [2:0] MOVE_WAIT    = 3'd4;
   localparam logic [2:0] MOVE_FINISH  = 3'd5;

   function automatic logic [DIST_W-1:0] reset_dist(input logic [CELL_W-1:0] idx);
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [DIST_W-1:0]  dx;
      logic [DIST_W-1:0]  dy;
      x  = idx[CELL_W-1:COORD_W];
      y  = idx[COORD_W-1:0];
      dx = (x < COORD_W'(HALF)) ? DIST_W'(COORD_W'(HALF - 1) - x) : DIST_W'(x - COORD_W'(HALF));
      dy = (y < COORD_W'(HALF)) ? DIST_W'(COORD_W'(HALF - 1) - y) : DIST_W'(y - COORD_W'(HALF));
      return dx + dy;
   endfunction
endpackage
`default_nettype wire

@@ rtl/maze_floodfill_navigator.sv @@
// Top level: micromouse modified floodfill navigator, sequencer and tables.
// After reset a clearing pass sweeps every cell of the wall map; busy stays high then.
// Per item: wall merge, then finish or seed the fill; each popped cell is dropped (distance
// zero), kept or raised; then the move is picked.
// Throughput: one item at a time; busy is high from acceptance until the rsp_valid cycle.
// Reset: synchronous, active high; clears control state and starts the clearing pass.
`default_nettype none
module maze_floodfill_navigator (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [3:0] req_pos_x,
   input  wire logic [3:0] req_pos_y,
   input  wire logic [1:0] req_mouse_heading,
   input  wire logic [3:0] req_walls_seen,
   output logic            rsp_valid,
   output logic [2:0]      rsp_move,
   output logic [8:0]      rsp_cell_distance,
   output logic            rsp_stack_overflow
);
   localparam int CW = mfn_pkg::CELL_W;
   localparam int DW = mfn_pkg::DIST_W;
   localparam int KW = mfn_pkg::COORD_W;

   // sequencer states
   localparam logic [4:0] S_CLEAR  = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_WRD    = 5'd2;  // read wall of cell/neighbour
   localparam logic [4:0] S_WWT    = 5'd3;  // wait for registered read
   localparam logic [4:0] S_WWR    = 5'd4;  // OR in and write back
   localparam logic [4:0] S_CHK    = 5'd5;  // centre test, start pushes
   localparam logic [4:0] S_PUSH0  = 5'd6;  // initial pushes
   localparam logic [4:0] S_POP    = 5'd7;
   localparam logic [4:0] S_PWT    = 5'd8;
   localparam logic [4:0] S_PCUR   = 5'd9;  // cell distance and walls arrive
   localparam logic [4:0] S_NRD    = 5'd10; // read neighbour distance
   localparam logic [4:0] S_NWT    = 5'd11;
   localparam logic [4:0] S_NCMP   = 5'd12; // compare neighbour distance with the minimum
   localparam logic [4:0] S_UPD    = 5'd13;
   localparam logic [4:0] S_PUSH1  = 5'd14;
   localparam logic [4:0] S_MRD    = 5'd15; // move: read own cell
   localparam logic [4:0] S_MWT    = 5'd16;
   localparam logic [4:0] S_MCUR   = 5'd17;
   localparam logic [4:0] S_MNRD   = 5'd18;
   localparam logic [4:0] S_MNWT   = 5'd19;
   localparam logic [4:0] S_MNCMP  = 5'd20;
   localparam logic [4:0] S_DONE   = 5'd21;
   localparam logic [4:0] S_FIN    = 5'd22;
   localparam logic [4:0] S_FWT    = 5'd23;

   // mv marker for the fetch of the merged walls ahead of the initial pushes
   localparam logic [2:0] MV_SEED  = 3'd7;

   logic [4:0] state_ff, state_in;
   logic [KW-1:0] x_ff, x_in, y_ff, y_in, cx_ff, cx_in, cy_ff, cy_in;
   logic [1:0] head_ff, head_in;
   logic [3:0] seen_ff, seen_in, cwall_ff, cwall_in;
   logic [2:0] dir_ff, dir_in;       // direction counter, 4 means "own cell"
   logic [DW-1:0] cur_ff, cur_in, min_ff, min_in;
   logic [mfn_pkg::SP_W-1:0] sp_ff, sp_in;
   logic ovf_ff, ovf_in;
   logic [2:0] mv_ff, mv_in;
   logic [CW:0] clr_ff, clr_in;
   logic [2:0] rmove_ff, rmove_in;
   logic [8:0] rdist_ff, rdist_in;
   logic rvalid_ff, rvalid_in, rovf_ff, rovf_in;

   // valid bit per distance entry: an unwritten entry reads as its reset distance
   logic [mfn_pkg::CELL_COUNT-1:0] dval_ff, dval_in;

   logic          d_we, w_we, s_we;
   logic [CW-1:0] d_addr, w_addr, d_addr_q_ff, d_addr_q_in;
   logic [DW-1:0] d_wdata, d_rraw, d_rdata;
   logic [3:0]    w_wdata, w_rdata;
   logic [mfn_pkg::SA_W-1:0] s_addr;
   logic [CW-1:0] s_wdata, s_rdata;

   mfn_ram #(.WIDTH(DW), .DEPTH(mfn_pkg::CELL_COUNT)) u_dist (
      .clock(clock), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rraw));
   mfn_ram #(.WIDTH(4), .DEPTH(mfn_pkg::CELL_COUNT)) u_wall (
      .clock(clock), .we(w_we), .addr(w_addr), .wdata(w_wdata), .rdata(w_rdata));
   mfn_ram #(.WIDTH(CW), .DEPTH(mfn_pkg::STACK_DEPTH)) u_stack (
      .clock(clock), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata));

   assign d_rdata = dval_ff[d_addr_q_ff] ? d_rraw : mfn_pkg::reset_dist(d_addr_q_ff);

   // neighbour of (px,py) in direction dd
   logic [1:0]    nb_d;
   logic [KW-1:0] nb_px, nb_py, nb_x, nb_y;
   logic          nb_ok;
   always_comb begin
      nb_x  = nb_px;
      nb_y  = nb_py;
      nb_ok = 1'b1;
      case (nb_d)
         2'd0: begin
            nb_y  = nb_py + 1'b1;
            nb_ok = (nb_py != KW'(mfn_pkg::MAZE_SIDE - 1));
         end
         2'd1: begin
            nb_x  = nb_px + 1'b1;
            nb_ok = (nb_px != KW'(mfn_pkg::MAZE_SIDE - 1));
         end
         2'd2: begin
            nb_y  = nb_py - 1'b1;
            nb_ok = (nb_py != '0);
         end
         default: begin
            nb_x  = nb_px - 1'b1;
            nb_ok = (nb_px != '0);
         end
      endcase
   end

   logic       centre;
   logic [1:0] rel_d;
   assign centre = (x_ff == KW'(mfn_pkg::HALF) || x_ff == KW'(mfn_pkg::HALF - 1)) &&
                   (y_ff == KW'(mfn_pkg::HALF) || y_ff == KW'(mfn_pkg::HALF - 1));
   // move search order: ahead, right, left, behind
   always_comb begin
      case (mv_ff[1:0])
         2'd0:    rel_d = head_ff;
         2'd1:    rel_d = head_ff + 2'd1;
         2'd2:    rel_d = head_ff + 2'd3;
         default: rel_d = head_ff + 2'd2;
      endcase
   end

   always_comb begin
      state_in = state_ff; x_in = x_ff; y_in = y_ff; cx_in = cx_ff; cy_in = cy_ff;
      head_in = head_ff; seen_in = seen_ff; cwall_in = cwall_ff; dir_in = dir_ff;
      cur_in = cur_ff; min_in = min_ff; sp_in = sp_ff; ovf_in = ovf_ff; mv_in = mv_ff;
      clr_in = clr_ff; dval_in = dval_ff; d_addr_q_in = d_addr;
      rmove_in = rmove_ff; rdist_in = rdist_ff; rovf_in = rovf_ff; rvalid_in = 1'b0;
      d_we = 1'b0; w_we = 1'b0; s_we = 1'b0;
      d_addr = {cx_ff, cy_ff}; d_wdata = min_ff + 1'b1;
      w_addr = {cx_ff, cy_ff}; w_wdata = '0;
      s_addr = mfn_pkg::SA_W'(sp_ff); s_wdata = '0;
      nb_px = cx_ff; nb_py = cy_ff; nb_d = dir_ff[1:0];
      case (state_ff)
         S_CLEAR: begin
            // sweep the wall map to all-open
            w_we    = 1'b1;
            w_addr  = clr_ff[CW-1:0];
            dval_in = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == (CW+1)'(mfn_pkg::CELL_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               x_in = req_pos_x; y_in = req_pos_y; head_in = req_mouse_heading;
               seen_in = req_walls_seen; cx_in = req_pos_x; cy_in = req_pos_y;
               dir_in = 3'd4; ovf_in = 1'b0; state_in = S_WRD;
            end
         end
         S_WRD: begin
            // own cell first, then the far side of each seen wall
            nb_px = x_ff; nb_py = y_ff;
            if (dir_ff == 3'd4) begin
               cx_in = x_ff; cy_in = y_ff; state_in = S_WWT;
            end else if (seen_ff[dir_ff[1:0]] && nb_ok) begin
               cx_in = nb_x; cy_in = nb_y; state_in = S_WWT;
            end else if (dir_ff == 3'd3) begin
               state_in = S_CHK;
            end else begin
               dir_in = dir_ff + 1'b1;
            end
         end
         S_WWT: begin
            state_in = S_WWR;
         end
         S_WWR: begin
            w_we = 1'b1;
            if (dir_ff == 3'd4) begin
               w_wdata = w_rdata | seen_ff;
               dir_in  = 3'd0;
            end else begin
               w_wdata = w_rdata | (4'b0001 << (dir_ff[1:0] + 2'd2));
               dir_in  = dir_ff + 1'b1;
            end
            state_in = (dir_ff == 3'd3) ? S_CHK : S_WRD;
         end
         S_CHK: begin
            cx_in = x_ff; cy_in = y_ff;
            if (centre) begin
               state_in = S_FIN;
            end else begin
               dir_in = 3'd4; state_in = S_PUSH0;
            end
         end
         S_PUSH0: begin
            // mouse cell, then neighbours behind walls (walls now merged: own walls are seen | old)
            nb_px = x_ff; nb_py = y_ff;
            if (dir_ff == 3'd4) begin
               s_we = 1'b1; s_wdata = {x_ff, y_ff}; sp_in = sp_ff + 1'b1;
               dir_in = 3'd0; cx_in = x_ff; cy_in = y_ff; state_in = S_MWT; mv_in = MV_SEED;
            end else begin
               if (cwall_ff[dir_ff[1:0]] && nb_ok) begin
                  if (sp_ff == mfn_pkg::SP_W'(mfn_pkg::STACK_DEPTH)) begin
                     ovf_in = 1'b1;
                  end else begin
                     s_we = 1'b1; s_wdata = {nb_x, nb_y}; sp_in = sp_ff + 1'b1;
                  end
               end
               dir_in = dir_ff + 1'b1;
               if (dir_ff == 3'd3) begin
                  state_in = S_POP;
               end
            end
         end
         S_POP: begin
            if (sp_ff == '0) begin
               cx_in = x_ff; cy_in = y_ff; mv_in = mfn_pkg::MOVE_FORWARD; state_in = S_MRD;
            end else begin
               s_addr = mfn_pkg::SA_W'(sp_ff - 1'b1); sp_in = sp_ff - 1'b1;
               state_in = S_PWT;
            end
         end
         S_PWT: begin
            cx_in = s_rdata[CW-1:KW]; cy_in = s_rdata[KW-1:0];
            d_addr = s_rdata; w_addr = s_rdata; state_in = S_PCUR;
         end
         S_PCUR: begin
            cur_in = d_rdata; cwall_in = w_rdata;
            min_in = mfn_pkg::UNREACHABLE; dir_in = 3'd0;
            state_in = (d_rdata == '0) ? S_POP : S_NRD;
         end
         S_NRD: begin
            if (!cwall_ff[dir_ff[1:0]] && nb_ok) begin
               d_addr = {nb_x, nb_y}; state_in = S_NWT;
            end else begin
               dir_in = dir_ff + 1'b1;
               if (dir_ff == 3'd3) begin
                  state_in = S_UPD;
               end
            end
         end
         S_NWT: begin
            // hold the neighbour address so its distance is still there to compare
            d_addr = {nb_x, nb_y};
            state_in = S_NCMP;
         end
         S_NCMP: begin
            if (d_rdata < min_ff) begin
               min_in = d_rdata;
            end
            dir_in = dir_ff + 1'b1;
            state_in = (dir_ff == 3'd3) ? S_UPD : S_NRD;
         end
         S_UPD: begin
            dir_in = 3'd0;
            if (cur_ff > min_ff || min_ff >= mfn_pkg::UNREACHABLE) begin
               state_in = S_POP;
            end else begin
               d_we = 1'b1;
               dval_in[{cx_ff, cy_ff}] = 1'b1;
               state_in = S_PUSH1;
            end
         end
         S_PUSH1: begin
            if (!cwall_ff[dir_ff[1:0]] && nb_ok) begin
               if (sp_ff == mfn_pkg::SP_W'(mfn_pkg::STACK_DEPTH)) begin
                  ovf_in = 1'b1;
               end else begin
                  s_we = 1'b1; s_wdata = {nb_x, nb_y}; sp_in = sp_ff + 1'b1;
               end
            end
            dir_in = dir_ff + 1'b1;
            if (dir_ff == 3'd3) begin
               state_in = S_POP;
            end
         end
         S_MRD: begin
            w_addr = {x_ff, y_ff}; d_addr = {x_ff, y_ff}; state_in = S_MWT;
         end
         S_MWT: begin
            state_in = S_MCUR;
         end
         S_MCUR: begin
            // the seed marker sends the merged walls back to the initial pushes
            cwall_in = w_rdata; cur_in = d_rdata;
            state_in = (mv_ff == MV_SEED) ? S_PUSH0 : S_MNRD;
            dir_in   = (mv_ff == MV_SEED) ? 3'd0 : dir_ff;
         end
         S_MNRD: begin
            nb_px = x_ff; nb_py = y_ff; nb_d = rel_d;
            if (mv_ff == mfn_pkg::MOVE_WAIT) begin
               state_in = S_DONE;
            end else if ((cwall_ff[rel_d] && mv_ff != mfn_pkg::MOVE_AROUND) || !nb_ok) begin
               mv_in = mv_ff + 1'b1;
            end else begin
               d_addr = {nb_x, nb_y}; state_in = S_MNWT;
            end
         end
         S_MNWT: begin
            // hold the neighbour address over the read
            nb_px = x_ff; nb_py = y_ff; nb_d = rel_d;
            d_addr = {nb_x, nb_y};
            state_in = S_MNCMP;
         end
         S_MNCMP: begin
            if (d_rdata < cur_ff) begin
               state_in = S_DONE;
            end else begin
               mv_in = mv_ff + 1'b1; state_in = S_MNRD;
            end
         end
         S_DONE: begin
            rvalid_in = 1'b1; rmove_in = mv_ff; rdist_in = 9'(cur_ff);
            rovf_in = ovf_ff; state_in = S_IDLE;
         end
         S_FIN: begin
            d_addr = {x_ff, y_ff}; state_in = S_FWT;
         end
         S_FWT: begin
            state_in = S_DONE; mv_in = mfn_pkg::MOVE_FINISH; ovf_in = 1'b0;
            cur_in = '0;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // finish distance is captured in the cycle after S_FWT
   logic fin_ff, fin_in;
   assign fin_in = (state_ff == S_FWT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; sp_ff <= '0; rvalid_ff <= 1'b0;
         dval_ff <= '0; fin_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; sp_ff <= sp_in; rvalid_ff <= rvalid_in;
         dval_ff <= dval_in; fin_ff <= fin_in;
      end
      x_ff <= x_in; y_ff <= y_in; cx_ff <= cx_in; cy_ff <= cy_in; head_ff <= head_in;
      seen_ff <= seen_in; cwall_ff <= cwall_in; dir_ff <= dir_in;
      cur_ff <= fin_ff ? d_rdata : cur_in;
      min_ff <= min_in; ovf_ff <= ovf_in; mv_ff <= mv_in; d_addr_q_ff <= d_addr_q_in;
      rmove_ff <= rmove_in; rdist_ff <= fin_ff ? 9'(d_rdata) : rdist_in; rovf_ff <= rovf_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rvalid_ff;
   assign rsp_move           = rmove_ff;
   assign rsp_cell_distance  = rdist_ff;
   assign rsp_stack_overflow = rovf_ff;
endmodule
`default_nettype wire

@@ rtl/mfn_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module mfn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire
